FILE: sv/sssd_pkg.sv
// Shared types and constants of the scale-space extremum detector.
// No dependencies; used by every module of the block.
`default_nettype none

package sssd_pkg;

	// Fixed field widths
	localparam int ROW_W        = 10;
	localparam int DIM_W        = 11;
	localparam int TAG_W        = 8;
	localparam int HEIGHT_LIMIT = 1024;
	localparam int CFG_IDX_W    = 2;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_TAG    = 2'd2;

	// Reset values of the registers
	localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
	localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 11'd480;
	localparam logic [TAG_W-1:0] RST_SCALE_TAG    = 8'd2;

	// Detection queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QLVL_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [TAG_W-1:0] scale;
	} sssd_cfg_t;

	// Position and polarity of one detection
	typedef struct packed {
		logic [ROW_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             is_min;
	} sssd_pos_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic [QLVL_W-1:0] level;
		logic              empty;
	} sssd_qstat_t;

endpackage

`default_nettype wire

FILE: sv/sssd_front.sv
// Front end: accepts pixel beats, tracks position, keeps the two line
// stores and the 3x3x3 window and classifies each centre. Uses sssd_pkg.
`default_nettype none

module sssd_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int VALUE_BITS = 24
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        in_start,
	input  wire logic [3*VALUE_BITS-1:0]     in_data,
	input  wire sssd_pkg::sssd_cfg_t         cfg,
	input  wire sssd_pkg::sssd_qstat_t       qstat,
	output logic                             push,
	output sssd_pkg::sssd_pos_t              push_pos,
	output logic signed [VALUE_BITS-1:0]     push_value
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = CW + 1;
	localparam int SW = 3 * VALUE_BITS;
	localparam int RW = sssd_pkg::ROW_W;
	localparam int DW = sssd_pkg::DIM_W;

	// Position counters
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// Stage 1: item with its line store reads
	logic          valid_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] ocol_s1;
	logic [RW-1:0] orow_s1;
	logic          chk_s1;
	logic [SW-1:0] cur_s1;
	logic [SW-1:0] rd_prev_s1;
	logic [SW-1:0] rd_old_s1;
	logic          fwd_s1;
	logic [SW-1:0] fwd_prev_s1;
	logic [SW-1:0] fwd_old_s1;

	// Stage 2: window holds the item, compare
	logic          valid_s2;
	logic [RW-1:0] ocol_s2;
	logic [RW-1:0] orow_s2;

	logic [SW-1:0] prev_mem [MAX_WIDTH];
	logic [SW-1:0] old_mem  [MAX_WIDTH];

	logic signed [VALUE_BITS-1:0] win_q [3][3][3];

	logic          accept;
	logic [WW-1:0] w_use;
	logic [DW-1:0] h_use;
	logic [CW-1:0] c0, c1;
	logic [RW-1:0] r0, r2;
	logic [DW-1:0] r1;
	logic [WW-1:0] ncol_w;
	logic [DW-1:0] nrow_w;
	logic [CW-1:0] col_nx;
	logic [RW-1:0] row_nx;
	logic [CW-1:0] cm1;
	logic [RW-1:0] rm1;
	logic          chk;
	logic [SW-1:0] prev_eff;
	logic [SW-1:0] old_eff;
	logic [sssd_pkg::QLVL_W-1:0] in_flight;
	logic          is_max, is_min;
	logic signed [VALUE_BITS-1:0] centre;

	// Credit check: every item in flight has a queue slot reserved
	always_comb begin
		in_flight = qstat.level + sssd_pkg::QLVL_W'(valid_s1) + sssd_pkg::QLVL_W'(valid_s2);
		in_ready  = in_flight < sssd_pkg::QLVL_W'(sssd_pkg::QDEPTH);
	end
	assign accept = in_valid && in_ready;

	// Frame size saturated to the supported range
	always_comb begin
		if (int'(cfg.width) > MAX_WIDTH) begin
			w_use = WW'(MAX_WIDTH);
		end else if (cfg.width < DW'(3)) begin
			w_use = WW'(3);
		end else begin
			w_use = WW'(cfg.width);
		end
		if (int'(cfg.height) > sssd_pkg::HEIGHT_LIMIT) begin
			h_use = DW'(sssd_pkg::HEIGHT_LIMIT);
		end else if (cfg.height < DW'(3)) begin
			h_use = DW'(3);
		end else begin
			h_use = cfg.height;
		end
	end

	// Position of the incoming beat and of the next one
	always_comb begin
		c0 = in_start ? '0 : col_q;
		r0 = in_start ? '0 : row_q;
		if ({1'b0, c0} >= w_use) begin
			c1 = '0;
			r1 = {1'b0, r0} + DW'(1);
		end else begin
			c1 = c0;
			r1 = {1'b0, r0};
		end
		r2     = (r1 >= h_use) ? '0 : r1[RW-1:0];
		ncol_w = {1'b0, c1} + WW'(1);
		nrow_w = {1'b0, r2} + DW'(1);
		if (ncol_w >= w_use) begin
			col_nx = '0;
			row_nx = (nrow_w >= h_use) ? '0 : nrow_w[RW-1:0];
		end else begin
			col_nx = ncol_w[CW-1:0];
			row_nx = r2;
		end
		chk = ({1'b0, c1} >= WW'(2)) && (r2 >= RW'(2));
		cm1 = c1 - CW'(1);
		rm1 = r2 - RW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_nx;
			row_q <= row_nx;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1 && chk_s1;
		end
	end

	// Stage payloads; forward when the previous beat writes the same column
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1      <= c1;
			ocol_s1     <= RW'(cm1);
			orow_s1     <= rm1;
			chk_s1      <= chk;
			cur_s1      <= in_data;
			fwd_s1      <= valid_s1 && (col_s1 == c1);
			fwd_prev_s1 <= cur_s1;
			fwd_old_s1  <= prev_eff;
		end
		if (valid_s1) begin
			ocol_s2 <= ocol_s1;
			orow_s2 <= orow_s1;
		end
	end

	assign prev_eff = fwd_s1 ? fwd_prev_s1 : rd_prev_s1;
	assign old_eff  = fwd_s1 ? fwd_old_s1 : rd_old_s1;

	// Line stores: read on accept, written as the beat leaves stage 1
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_prev_s1 <= prev_mem[c1];
			rd_old_s1  <= old_mem[c1];
		end
		if (valid_s1) begin
			prev_mem[col_s1] <= cur_s1;
			old_mem[col_s1]  <= prev_eff;
		end
	end

	// Window shift: rows older, previous, current; columns oldest to newest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < 3; s++) begin
				for (int r = 0; r < 3; r++) begin
					for (int c = 0; c < 3; c++) begin
						win_q[s][r][c] <= '0;
					end
				end
			end
		end else if (valid_s1) begin
			for (int s = 0; s < 3; s++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[s][r][0] <= win_q[s][r][1];
					win_q[s][r][1] <= win_q[s][r][2];
				end
				win_q[s][0][2] <= old_eff[s*VALUE_BITS +: VALUE_BITS];
				win_q[s][1][2] <= prev_eff[s*VALUE_BITS +: VALUE_BITS];
				win_q[s][2][2] <= cur_s1[s*VALUE_BITS +: VALUE_BITS];
			end
		end
	end

	// Centre against its 26 neighbours
	always_comb begin
		centre = win_q[1][1][1];
		is_max = 1'b1;
		is_min = 1'b1;
		for (int s = 0; s < 3; s++) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					if (!(s == 1 && r == 1 && c == 1)) begin
						if (!(centre >= win_q[s][r][c])) is_max = 1'b0;
						if (!(centre < win_q[s][r][c])) is_min = 1'b0;
					end
				end
			end
		end
	end

	assign push            = valid_s2 && (is_max || is_min);
	assign push_pos.col    = ocol_s2;
	assign push_pos.row    = orow_s2;
	assign push_pos.is_min = !is_max;
	assign push_value      = centre;

endmodule

`default_nettype wire

FILE: sv/sssd_queue.sv
// Short detection queue between front and back, QDEPTH entries.
// Depends on sssd_pkg for depth and status type.
`default_nettype none

module sssd_queue #(
	parameter int DW = 45
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire logic [DW-1:0]         push_data,
	input  wire logic                  pop,
	output logic [DW-1:0]              head_data,
	output sssd_pkg::sssd_qstat_t      qstat
);

	logic [DW-1:0]                 entry_q [sssd_pkg::QDEPTH];
	logic [sssd_pkg::QPTR_W-1:0]   wptr_q;
	logic [sssd_pkg::QPTR_W-1:0]   rptr_q;
	logic [sssd_pkg::QLVL_W-1:0]   level_q;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + sssd_pkg::QPTR_W'(1);
			if (pop)  rptr_q <= rptr_q + sssd_pkg::QPTR_W'(1);
			if (push && !pop) begin
				level_q <= level_q + sssd_pkg::QLVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - sssd_pkg::QLVL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wptr_q] <= push_data;
	end

	assign head_data   = entry_q[rptr_q];
	assign qstat.level = level_q;
	assign qstat.empty = (level_q == '0);

endmodule

`default_nettype wire

FILE: sv/sssd_back.sv
// Back end: output register that drains the detection queue and packs
// the result beat. Depends on sssd_pkg.
`default_nettype none

module sssd_back #(
	parameter int VALUE_BITS = 24
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire sssd_pkg::sssd_qstat_t          qstat,
	input  wire sssd_pkg::sssd_pos_t            head_pos,
	input  wire logic signed [VALUE_BITS-1:0]   head_value,
	input  wire logic [sssd_pkg::TAG_W-1:0]     scale,
	output logic                                pop,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [((2*sssd_pkg::ROW_W+VALUE_BITS+sssd_pkg::TAG_W+7)/8)*8-1:0] m_tdata,
	output logic                                m_tuser
);

	localparam int OUT_W = ((2*sssd_pkg::ROW_W + VALUE_BITS + sssd_pkg::TAG_W + 7) / 8) * 8;

	logic                          valid_q;
	sssd_pkg::sssd_pos_t           pos_q;
	logic [VALUE_BITS-1:0]         value_q;
	logic [sssd_pkg::TAG_W-1:0]    scale_q;

	// Load when the register is empty or its beat is taken
	assign pop = !qstat.empty && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pos_q   <= head_pos;
			value_q <= head_value;
			scale_q <= scale;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = OUT_W'({scale_q, value_q, pos_q.row, pos_q.col});
	assign m_tuser  = pos_q.is_min;

endmodule

`default_nettype wire

FILE: sv/scale_space_extremum_detect.sv
// Top level of the scale-space extremum detector: configuration registers,
// front end, detection queue and output stage. Depends on sssd_pkg.
//
// Takes one pixel beat per clock while s_tready is high, in raster order,
// each with LoG responses of three adjacent scales, and reports the
// middle-scale pixel one row up and one column back when it is >= all 26
// window neighbours (maximum) or below all of them (minimum); border pixels
// are never reported. The sustained rate is one beat per cycle, set by the
// single read and single write port of each line store per cycle (a
// same-column write/read is forwarded). s_tready drops only when the
// four-entry detection queue could not hold every beat still in flight, so
// a stalled output stops input once the queued detections and the beats in
// flight reach the queue depth. Line stores are not cleared; a window read
// of a column never written since reset (only possible if the width grows
// inside a frame) gives undefined data. Configure only while idle.
`default_nettype none

module scale_space_extremum_detect #(
	parameter int MAX_WIDTH  = 1024,
	parameter int VALUE_BITS = 24
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// s_tdata: lower_value, middle_value, upper_value (lowest bit up)
	input  wire logic [((3*VALUE_BITS+7)/8)*8-1:0]      s_tdata,
	// s_tuser: frame_start
	input  wire logic                                   s_tuser,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// m_tdata: blob_column, blob_row, blob_value, blob_scale (lowest bit up)
	output logic [((2*sssd_pkg::ROW_W+VALUE_BITS+sssd_pkg::TAG_W+7)/8)*8-1:0] m_tdata,
	// m_tuser: is_minimum
	output logic                                        m_tuser,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	input  wire logic                                   cfg_we,
	input  wire logic [sssd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [sssd_pkg::DIM_W-1:0]             cfg_data
);

	localparam int QW = $bits(sssd_pkg::sssd_pos_t) + VALUE_BITS;

	sssd_pkg::sssd_cfg_t      cfg_q;
	sssd_pkg::sssd_qstat_t    qstat;
	sssd_pkg::sssd_pos_t      push_pos;
	sssd_pkg::sssd_pos_t      head_pos;
	logic signed [VALUE_BITS-1:0] push_value;
	logic signed [VALUE_BITS-1:0] head_value;
	logic                     push;
	logic                     pop;
	logic [QW-1:0]            head_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= sssd_pkg::RST_IMAGE_WIDTH;
			cfg_q.height <= sssd_pkg::RST_IMAGE_HEIGHT;
			cfg_q.scale  <= sssd_pkg::RST_SCALE_TAG;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sssd_pkg::REG_IMAGE_WIDTH:  cfg_q.width  <= cfg_data;
				sssd_pkg::REG_IMAGE_HEIGHT: cfg_q.height <= cfg_data;
				sssd_pkg::REG_SCALE_TAG:    cfg_q.scale  <= cfg_data[sssd_pkg::TAG_W-1:0];
				default: ;
			endcase
		end
	end

	sssd_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_start   (s_tuser),
		.in_data    (s_tdata[3*VALUE_BITS-1:0]),
		.cfg        (cfg_q),
		.qstat      (qstat),
		.push       (push),
		.push_pos   (push_pos),
		.push_value (push_value)
	);

	sssd_queue #(
		.DW (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_pos, push_value}),
		.pop       (pop),
		.head_data (head_data),
		.qstat     (qstat)
	);

	assign head_pos   = head_data[QW-1:VALUE_BITS];
	assign head_value = head_data[VALUE_BITS-1:0];

	sssd_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.head_pos   (head_pos),
		.head_value (head_value),
		.scale      (cfg_q.scale),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

`default_nettype wire

FILE: sv/sssd_checker.sv
// Port-level checks of the scale-space extremum detector, bound to the top.
// Depends on sssd_pkg for field widths.
`default_nettype none

module sssd_checker #(
	parameter int VALUE_BITS = 24
) (
	input wire logic                                   clk,
	input wire logic                                   arst_n,
	input wire logic [((2*sssd_pkg::ROW_W+VALUE_BITS+sssd_pkg::TAG_W+7)/8)*8-1:0] m_tdata,
	input wire logic                                   m_tuser,
	input wire logic                                   m_tvalid,
	input wire logic                                   m_tready
);

	localparam int RW = sssd_pkg::ROW_W;

	// A stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// ... and unchanged
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// No detection lies in row or column zero or at the all-ones field value
	a_no_border: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[RW-1:0] != '0) && (m_tdata[2*RW-1:RW] != '0)
			&& (m_tdata[RW-1:0] != '1) && (m_tdata[2*RW-1:RW] != '1))
		else $error("detection on the frame border");

	// Nothing is offered while reset is held
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result beat during reset");

endmodule

bind scale_space_extremum_detect sssd_checker #(
	.VALUE_BITS (VALUE_BITS)
) u_sssd_checker (.*);

`default_nettype wire
